// File: rtl/ssf_pkg.sv
// ssf_pkg: shared types, register codes and constants for the sensor sample filter
// used by ssf_ctrl, ssf_datapath and sensor_sample_filter; no dependencies
`timescale 1ns / 1ps

package ssf_pkg;

  // default sizes
  localparam int MAX_WINDOW_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration register widths
  localparam int MODE_W     = 2;
  localparam int WIN_W      = 5;
  localparam int ALPHA_W    = 9;
  localparam int LIMIT_W    = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;

  // configuration reset values
  localparam logic [WIN_W-1:0]   WINDOW_RST = WIN_W'(4);
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = ALPHA_W'(77);
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(80);

  // exponential average: alpha of one in q1.8, rounding half and shift
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);
  localparam int EMA_ROUND = 128;
  localparam int EMA_SHIFT = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASS  = 2'd0,
    MODE_AVG   = 2'd1,
    MODE_EMA   = 2'd2,
    MODE_SPIKE = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WINDOW = 2'd1,
    REG_ALPHA  = 2'd2,
    REG_LIMIT  = 2'd3
  } reg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic rd_old;
    logic div_start;
    logic div_step;
    logic mul_a;
    logic mul_b;
    logic mul_acc;
    logic update;
    logic emit;
    logic sw_start;
    logic sw_rd;
    logic sw_add;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic  trim;
    logic  is_valid;
    logic  count_zero;
    logic  div_done;
    logic  sw_done;
    mode_t mode;
  } sts_t;

endpackage

// File: rtl/sensor_sample_filter.sv
// sensor_sample_filter: top level, stream ports, output register stage
// depends on ssf_pkg, ssf_ctrl and ssf_datapath
`timescale 1ns / 1ps

// Filters signed Q11.4 sensor samples one word at a time. A word is accepted when
// in_tready is high, which happens whenever the sequencer is idle and no shrinking
// window_size is being written, even while the previous result still waits in the
// output register. An invalid sample goes from the read state straight to output;
// pass-through and spike rejection pass the update state first, the exponential
// average forms two products through one shared multiplier before the update
// (skipped with an empty window) and the moving average runs the radix-2 divider,
// which produces one quotient bit per cycle. A new word can be taken the cycle after
// its result is handed to the output register. A window_size write below the current
// fill while idle recounts the running sum over the kept ring entries, in_tready low.
module sensor_sample_filter import ssf_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // sample_value
  input  logic                  in_tuser,   // sample_valid
  // output stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // out_value, zero padded
  output logic                  out_tuser   // out_valid
);

  cmd_t                   cmd;
  sts_t                   sts;
  logic                   res_valid;
  logic [SAMPLE_BITS-1:0] res_value;
  logic                   out_free;

  logic                   out_vld_r;
  logic                   out_user_r;
  logic [SAMPLE_BITS-1:0] out_data_r;

  ssf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssf_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .sample_valid (in_tuser),
    .sample_value (in_tdata[SAMPLE_BITS-1:0]),
    .cmd          (cmd),
    .sts          (sts),
    .res_valid    (res_valid),
    .res_value    (res_value)
  );

  // output register stage
  assign out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_user_r <= res_valid;
      out_data_r <= res_value;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = TDATA_W'(out_data_r);

endmodule

// File: rtl/ssf_datapath.sv
// ssf_datapath: config registers, history ring memory, running sum, radix-2 divider,
// shared multiplier for the exponential average and spike check; depends on ssf_pkg
`timescale 1ns / 1ps

module ssf_datapath import ssf_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   sample_valid,
  input  logic [SAMPLE_BITS-1:0] sample_value,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic                   res_valid,
  output logic [SAMPLE_BITS-1:0] res_value
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int CNT1_W = $clog2(MAX_WINDOW + 2);
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int ADR_W  = CNT1_W + 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
  localparam int IT_W   = $clog2(SUM_W + 1);
  localparam int EMA_W  = SAMPLE_BITS + ALPHA_W + 1;
  localparam int CMP_W  = (SAMPLE_BITS + 1 > LIMIT_W) ? SAMPLE_BITS + 1 : LIMIT_W;

  // window size clamped to the ring depth
  function automatic logic [CNT_W-1:0] eff_of(input logic [WIN_W-1:0] win);
    logic [CNT_W-1:0] e;
    if (int'(win) > MAX_WINDOW) begin
      e = CNT_W'(MAX_WINDOW);
    end else begin
      e = CNT_W'(win);
    end
    return e;
  endfunction

  // ring slot that lies back entries behind the write slot
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] ws,
                                                  input logic [CNT1_W-1:0] back);
    logic [ADR_W-1:0] t;
    t = ADR_W'(ws) + ADR_W'(MAX_WINDOW) - ADR_W'(back);
    if (t >= ADR_W'(MAX_WINDOW)) begin
      t = t - ADR_W'(MAX_WINDOW);
    end
    return t[SLOT_W-1:0];
  endfunction

  // configuration registers
  mode_t              mode_r;
  logic [WIN_W-1:0]   win_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [LIMIT_W-1:0] limit_r;

  // filter state
  logic [CNT_W-1:0]              count_r;
  logic [SLOT_W-1:0]             ws_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic signed [SAMPLE_BITS-1:0] lf_r;
  logic signed [SAMPLE_BITS-1:0] lraw_r;

  // per-word working registers
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          xv_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic signed [SAMPLE_BITS-1:0] rdata_r;
  logic signed [EMA_W-1:0]       prod_r;
  logic signed [EMA_W-1:0]       acc_r;
  logic [CNT1_W-1:0]             rem_r;
  logic [SUM_W-1:0]              quo_r;
  logic                          neg_r;
  logic [IT_W-1:0]               it_r;
  logic [CNT1_W-1:0]             sidx_r;

  logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];

  logic [CNT_W-1:0]        weff;
  logic [CNT_W-1:0]        new_eff;
  logic                    trim;
  logic                    mem_we;
  logic                    mem_re;
  logic [SLOT_W-1:0]       raddr;
  logic [SLOT_W-1:0]       ws_inc;

  logic signed [SUM_W-1:0] num;
  logic [SUM_W-1:0]        num_u;
  logic [SUM_W-1:0]        mag;
  logic [CNT1_W-1:0]       dvs;
  logic [CNT1_W:0]         trial;
  logic [CNT1_W:0]         trial_sub;
  logic [SUM_W-1:0]        qs;

  logic [ALPHA_W-1:0]        a_eff;
  logic [ALPHA_W-1:0]        b_eff;
  logic signed [ALPHA_W:0]   mop_a;
  logic signed [SAMPLE_BITS-1:0] mop_b;
  logic signed [EMA_W-1:0]   mul_p;

  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS:0]        diff_u;
  logic [SAMPLE_BITS:0]        adiff;
  logic                        spike;
  logic signed [SAMPLE_BITS-1:0] y_sel;

  assign weff    = eff_of(win_r);
  assign new_eff = eff_of(cfg_wdata[WIN_W-1:0]);
  assign trim    = cfg_we && (cfg_index == REG_WINDOW) && (count_r > new_eff);

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PASS;
      win_r   <= WINDOW_RST;
      alpha_r <= ALPHA_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:   mode_r  <= mode_t'(cfg_wdata[MODE_W-1:0]);
        REG_WINDOW: win_r   <= cfg_wdata[WIN_W-1:0];
        REG_ALPHA:  alpha_r <= cfg_wdata[ALPHA_W-1:0];
        REG_LIMIT:  limit_r <= cfg_wdata[LIMIT_W-1:0];
      endcase
    end
  end

  // ring memory, one write and one registered read
  assign ws_inc = (ws_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : ws_r + 1'b1;
  assign mem_we = cmd.update && (weff != '0);
  assign mem_re = cmd.rd_old || cmd.sw_rd;
  assign raddr  = cmd.sw_rd ? slot_back(ws_r, sidx_r) : slot_back(ws_r, CNT1_W'(weff));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[ws_r] <= x_r;
    end
    if (mem_re) begin
      rdata_r <= ring_mem[raddr];
    end
  end

  // divider operands: sum plus sample over count plus one
  assign num   = sum_r + SUM_W'(x_r);
  assign num_u = num;
  assign mag   = num[SUM_W-1] ? (~num_u + 1'b1) : num_u;
  assign dvs   = CNT1_W'(count_r) + 1'b1;
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign qs    = neg_r ? (~quo_r + 1'b1) : quo_r;

  // shared multiplier for both ema products
  assign a_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign b_eff = ALPHA_ONE - a_eff;
  assign mop_a = cmd.mul_b ? $signed({1'b0, b_eff}) : $signed({1'b0, a_eff});
  assign mop_b = cmd.mul_b ? lf_r : x_r;
  assign mul_p = EMA_W'(mop_a) * EMA_W'(mop_b);

  // spike check against newest stored raw sample
  assign diff   = (SAMPLE_BITS + 1)'(x_r) - (SAMPLE_BITS + 1)'(lraw_r);
  assign diff_u = diff;
  assign adiff  = diff[SAMPLE_BITS] ? (~diff_u + 1'b1) : diff_u;
  assign spike  = CMP_W'(adiff) > CMP_W'(limit_r);

  // filtered value by mode
  always_comb begin
    unique case (mode_r)
      MODE_PASS:  y_sel = x_r;
      MODE_AVG:   y_sel = qs[SAMPLE_BITS-1:0];
      MODE_EMA:   y_sel = (count_r == '0) ? x_r : acc_r[EMA_SHIFT +: SAMPLE_BITS];
      MODE_SPIKE: y_sel = ((count_r != '0) && spike) ? lraw_r : x_r;
    endcase
  end

  // history count, write slot, running sum and last filtered value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ws_r    <= '0;
      sum_r   <= '0;
      lf_r    <= '0;
    end else begin
      if (trim) begin
        count_r <= new_eff;
      end else if (cmd.update && (weff != '0) && (count_r < weff)) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.sw_start) begin
        sum_r <= '0;
      end else if (cmd.sw_add) begin
        sum_r <= sum_r + SUM_W'(rdata_r);
      end else if (cmd.update && (weff != '0)) begin
        if (count_r < weff) begin
          sum_r <= sum_r + SUM_W'(x_r);
        end else begin
          sum_r <= sum_r + SUM_W'(x_r) - SUM_W'(rdata_r);
        end
      end
      if (cmd.update) begin
        lf_r <= y_sel;
        if (weff != '0) begin
          ws_r <= ws_inc;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r  <= sample_value;
      xv_r <= sample_valid;
    end
    if (cmd.update) begin
      y_r <= y_sel;
      if (weff != '0) begin
        lraw_r <= x_r;
      end
    end
    if (cmd.div_start) begin
      quo_r <= mag;
      rem_r <= '0;
      neg_r <= num[SUM_W-1];
      it_r  <= IT_W'(SUM_W);
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, dvs}) begin
        rem_r <= trial_sub[CNT1_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[CNT1_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
      it_r <= it_r - 1'b1;
    end
    if (cmd.mul_a) begin
      prod_r <= mul_p;
    end else if (cmd.mul_b) begin
      acc_r  <= prod_r;
      prod_r <= mul_p;
    end else if (cmd.mul_acc) begin
      acc_r <= acc_r + prod_r + EMA_W'(EMA_ROUND);
    end
    if (cmd.sw_start) begin
      sidx_r <= CNT1_W'(1);
    end else if (cmd.sw_add) begin
      sidx_r <= sidx_r + 1'b1;
    end
  end

  // status and result
  assign sts.trim       = trim;
  assign sts.is_valid   = xv_r;
  assign sts.count_zero = (count_r == '0);
  assign sts.div_done   = (it_r == IT_W'(1));
  assign sts.sw_done    = (sidx_r > CNT1_W'(count_r));
  assign sts.mode       = mode_r;

  assign res_valid = xv_r;
  assign res_value = xv_r ? y_r : x_r;

endmodule

// File: rtl/ssf_ctrl.sv
// ssf_ctrl: sequencer for one word at a time and for the sum recount after a window shrink
// depends on ssf_pkg; drives ssf_datapath through cmd_t and reads sts_t
`timescale 1ns / 1ps

module ssf_ctrl import ssf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_free,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_MULB  = 9'b000001000,
    S_MACC  = 9'b000010000,
    S_UPD   = 9'b000100000,
    S_DONE  = 9'b001000000,
    S_SWRD  = 9'b010000000,
    S_SWADD = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE) && !sts.trim;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (sts.trim) begin
          cmd.sw_start = 1'b1;
          state_nxt    = S_SWRD;
        end else if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_old = 1'b1;
        if (!sts.is_valid) begin
          state_nxt = S_DONE;
        end else if (sts.mode == MODE_AVG) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if ((sts.mode == MODE_EMA) && !sts.count_zero) begin
          cmd.mul_a = 1'b1;
          state_nxt = S_MULB;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_UPD;
        end
      end
      S_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_MACC;
      end
      S_MACC: begin
        cmd.mul_acc = 1'b1;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SWRD: begin
        if (sts.trim) begin
          cmd.sw_start = 1'b1;
        end else if (sts.sw_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.sw_rd = 1'b1;
          state_nxt = S_SWADD;
        end
      end
      S_SWADD: begin
        if (sts.trim) begin
          cmd.sw_start = 1'b1;
        end else begin
          cmd.sw_add = 1'b1;
        end
        state_nxt = S_SWRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/ssf_checker.sv
// ssf_checker: port-level assertions for sensor_sample_filter, bound to the top level
// no package dependency
`timescale 1ns / 1ps

module ssf_checker #(
  parameter int TDATA_W = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic               out_tuser
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // no output word right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // one word at a time: input closes after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on back to back cycles");

  // a result never appears the cycle after an accept
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

endmodule

bind sensor_sample_filter ssf_checker #(
  .TDATA_W (TDATA_W)
) u_ssf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/ssf_filter_checker.sv
// ssf_filter_checker: watches the stream and config ports of sensor_sample_filter,
// predicts every filtered word and compares it with what the block emits
// depends on ssf_pkg only
`timescale 1ns / 1ps

module ssf_filter_checker import ssf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [15:0]            in_tdata,    // sample_value
  input  logic                   in_tuser,    // sample_valid
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [15:0]            out_tdata,   // out_value
  input  logic                   out_tuser,   // out_valid
  output int                     fail_count,
  output int                     pending_count,
  output int                     checked_count
);

  localparam int SW        = SAMPLE_BITS_DEF;
  localparam int MAXW      = MAX_WINDOW_DEF;
  localparam int DUE_DEPTH = 16;

  typedef struct packed {
    logic                 flag;
    logic signed [SW-1:0] value;
  } filt_word_t;

  // filtered words still owed by the block, oldest first
  filt_word_t  filtered_due [DUE_DEPTH];
  int unsigned due_rd;
  int unsigned due_wr;

  // shadow of the filter history
  logic signed [SW-1:0] hist_ring [MAXW];
  int unsigned          hist_fill;
  int unsigned          wr_slot;
  longint               hist_sum;
  logic signed [SW-1:0] prev_filtered;

  // shadow of the register file
  mode_t                cur_mode;
  logic [WIN_W-1:0]     cur_window;
  logic [ALPHA_W-1:0]   cur_alpha;
  logic [LIMIT_W-1:0]   cur_limit;

  function automatic int unsigned eff_window();
    return (cur_window > MAXW) ? MAXW : cur_window;
  endfunction

  function automatic int unsigned ring_back(int unsigned n);
    return (wr_slot + 2 * MAXW - n) % MAXW;
  endfunction

  // sum of the newest hist_fill raw samples
  function automatic longint window_total();
    longint s;
    s = 0;
    for (int unsigned i = 1; i <= hist_fill; i++) s += hist_ring[ring_back(i)];
    return s;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (reg_idx_t'(idx))
      REG_MODE:   cur_mode = mode_t'(data[MODE_W-1:0]);
      REG_WINDOW: begin
        cur_window = data[WIN_W-1:0];
        // shrinking the window drops the oldest entries at once
        if (hist_fill > eff_window()) begin
          hist_fill = eff_window();
          hist_sum  = window_total();
        end
      end
      REG_ALPHA:  cur_alpha = data[ALPHA_W-1:0];
      REG_LIMIT:  cur_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // filters one accepted word and, for a valid one, advances the history
  function automatic filt_word_t filter_word(logic vld, logic signed [SW-1:0] x);
    longint     xs, yv, a, t, prev, d, lim;
    int unsigned w;
    filt_word_t r;
    xs = x;
    yv = xs;
    r.flag = vld;
    r.value = x;
    if (!vld) return r;
    case (cur_mode)
      MODE_AVG: yv = (hist_sum + xs) / longint'(hist_fill + 1);
      MODE_EMA: begin
        if (hist_fill != 0) begin
          a = cur_alpha;
          if (cur_alpha > ALPHA_ONE) a = 256;
          t = a * xs + (256 - a) * longint'(prev_filtered);
          yv = (t + EMA_ROUND) >>> EMA_SHIFT;
        end
      end
      MODE_SPIKE: begin
        if (hist_fill != 0) begin
          prev = hist_ring[ring_back(1)];
          lim = cur_limit;
          d = xs - prev;
          if (d < 0) d = -d;
          if (d > lim) yv = prev;
        end
      end
      default: ;
    endcase
    prev_filtered = yv[SW-1:0];
    w = eff_window();
    if (w != 0) begin
      hist_ring[wr_slot] = x;
      wr_slot = (wr_slot + 1) % MAXW;
      if (hist_fill < w) hist_fill++;
      hist_sum = window_total();
    end
    r.value = yv[SW-1:0];
    return r;
  endfunction

  // result side first, so a word that shows up with nothing owed is caught
  always @(posedge clk) begin
    filt_word_t want;
    if (!rst_n) begin
      due_rd = 0;
      due_wr = 0;
      foreach (hist_ring[i]) hist_ring[i] = '0;
      hist_fill = 0;
      wr_slot = 0;
      hist_sum = 0;
      prev_filtered = '0;
      cur_mode = MODE_PASS;
      cur_window = WINDOW_RST;
      cur_alpha = ALPHA_RST;
      cur_limit = LIMIT_RST;
      fail_count = 0;
      checked_count = 0;
    end else begin
      if (cfg_we) apply_cfg(cfg_index, cfg_wdata);
      if (out_tvalid && out_tready) begin
        if (due_wr == due_rd) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: flag %0b value %0d", out_tuser,
                     $signed(out_tdata));
        end else begin
          want = filtered_due[due_rd % DUE_DEPTH];
          due_rd++;
          checked_count++;
          if (out_tuser !== want.flag || out_tdata !== want.value) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch on word %0d: expected flag %0b value %0d, got flag %0b value %0d",
                       checked_count, want.flag, want.value, out_tuser,
                       $signed(out_tdata));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        filtered_due[due_wr % DUE_DEPTH] = filter_word(in_tuser, in_tdata);
        due_wr++;
      end
    end
    pending_count = int'(due_wr - due_rd);
  end

endmodule

// File: tb/tb_sensor_sample_filter.sv
// tb_sensor_sample_filter: stimulus and verdict for sensor_sample_filter
// depends on ssf_pkg, the filter rtl and ssf_filter_checker
`timescale 1ns / 1ps

module tb_sensor_sample_filter import ssf_pkg::*;;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;   // sample_value
  logic                  in_tuser = 1'b0; // sample_valid
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;      // out_value
  logic                  out_tuser;      // out_valid

  int fail_count, pending_count, checked_count;
  int snd_idle = 9;
  int rcv_idle = 82;
  int words_sent = 0;
  int valid_sent = 0;
  int settings_seen = 0;
  int unsigned lim_now = LIMIT_RST;
  logic [15:0] last_raw = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sensor_sample_filter uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  ssf_filter_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .fail_count(fail_count), .pending_count(pending_count), .checked_count(checked_count)
  );

  // receiver stalls at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // one word on the input stream, with a random gap before it
  task automatic send_word(input logic vld, input logic [15:0] val);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= val;
    in_tuser <= vld;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    words_sent++;
    if (vld) valid_sent++;
    last_raw = val;
  endtask

  // hold off the sender until every owed word is out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    // a shrinking window makes the block recount its sum
    while (!in_tready) @(negedge clk);
    if (idx == REG_LIMIT) lim_now = val;
    settings_seen++;
  endtask

  // mostly steps near the last raw value, sometimes extremes or full range
  function automatic logic [15:0] pick_value();
    int kind, span, v;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h7fff;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    if (kind <= 3) return 16'($urandom);
    span = (lim_now > 40000) ? 40000 : lim_now + 2;
    v = int'($signed(last_raw)) + int'($urandom_range(0, 2 * span)) - span;
    return v[15:0];
  endfunction

  task automatic random_settings();
    int unsigned win, alpha, lim;
    case ($urandom_range(0, 9))
      0: win = 0;
      1: win = 16;
      2: win = $urandom_range(17, 31);
      default: win = $urandom_range(1, 15);
    endcase
    case ($urandom_range(0, 7))
      0: alpha = 0;
      1: alpha = 256;
      2: alpha = $urandom_range(257, 511);
      default: alpha = $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 7))
      0: lim = 0;
      1: lim = 32767;
      2: lim = $urandom_range(0, 32767);
      default: lim = $urandom_range(0, 400);
    endcase
    write_reg(REG_MODE, $urandom_range(0, 3));
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_WINDOW, win);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pass-through, invalid and valid words at both extremes
    write_reg(REG_MODE, MODE_PASS);
    send_word(1'b0, 16'h8000);
    send_word(1'b0, 16'h7fff);
    send_word(1'b1, 16'h7fff);
    send_word(1'b1, 16'h8000);
    send_word(1'b1, 16'h0000);

    // moving average with a window of 16, fed with extremes
    write_reg(REG_WINDOW, 16);
    write_reg(REG_MODE, MODE_AVG);
    repeat (3) send_word(1'b1, 16'h7fff);
    repeat (3) send_word(1'b1, 16'h8000);
    send_word(1'b1, 16'hffff);
    send_word(1'b0, 16'h0005);

    // exponential average at full, zero and clamped weight
    write_reg(REG_MODE, MODE_EMA);
    write_reg(REG_ALPHA, 256);
    send_word(1'b1, 16'h8000);
    write_reg(REG_ALPHA, 0);
    send_word(1'b1, 16'h7fff);
    write_reg(REG_ALPHA, 511);
    send_word(1'b1, 16'h0123);

    // spike rejection: zero limit, widest jump, jump equal to the limit
    write_reg(REG_MODE, MODE_SPIKE);
    write_reg(REG_LIMIT, 0);
    send_word(1'b1, 16'h000a);
    send_word(1'b1, 16'h000a);
    send_word(1'b1, 16'h000b);
    write_reg(REG_LIMIT, 32767);
    send_word(1'b1, 16'h7fff);
    send_word(1'b1, 16'h8000);
    write_reg(REG_LIMIT, 5);
    send_word(1'b1, 16'h8005);

    // empty window: every mode returns the raw value
    write_reg(REG_WINDOW, 0);
    send_word(1'b1, 16'h1234);
    write_reg(REG_MODE, MODE_EMA);
    send_word(1'b1, 16'h4321);
    write_reg(REG_MODE, MODE_AVG);
    send_word(1'b1, 16'h8000);
    write_reg(REG_WINDOW, 31);

    // random part: three idling patterns, six settings each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle = 9;  rcv_idle = 82; end
        1: begin snd_idle = 82; rcv_idle = 9;  end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      for (int seg = 0; seg < 6; seg++) begin
        random_settings();
        for (int k = 0; k < 75; k++) begin
          if (k == 40 && $urandom_range(0, 2) == 0) drain();
          send_word($urandom_range(0, 99) < 85, pick_value());
        end
      end
    end

    drain();
    repeat (40) @(negedge clk);
    $display("covered %0d words (%0d valid) across %0d register writes, %0d results checked",
             words_sent, valid_sent, settings_seen, checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures, %0d words still owed", fail_count, pending_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("timeout with %0d words still owed", pending_count);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/ssf_pkg.sv
rtl/ssf_datapath.sv
rtl/ssf_ctrl.sv
rtl/sensor_sample_filter.sv
rtl/ssf_checker.sv
tb/ssf_filter_checker.sv
tb/tb_sensor_sample_filter.sv
